>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the console RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console package
// Request and response payloads, opcodes, register indexes and character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FG_COLOR = 1'b0,
    CFG_BG_COLOR = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_PUT_CHAR   = 2'd0,
    OP_CLEAR      = 2'd1,
    OP_SET_CURSOR = 2'd2,
    OP_READ_CELL  = 2'd3
  } opcode_t;

  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_RETURN    = 8'h0D;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] CHAR_BLANK     = 8'h20;

  localparam logic [3:0] FG_RESET = 4'h7;
  localparam logic [3:0] BG_RESET = 4'h0;

  localparam logic [15:0] RESET_BLANK = {BG_RESET, FG_RESET, CHAR_BLANK};

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [7:0] column;
    logic [5:0] row_index;
  } req_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
  } rsp_t;

endpackage

>>> src/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// Screen store RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/text_console_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// Text console cell writer
// A request is taken only in IDLE and runs EXEC then FINISH; read cell adds
// READ, and clear screen sweeps the whole store to blanks in FILL first.
// A scroll copies each row up one row in MOVE, then blanks the bottom row in
// FILL, bound by the single store write port. FINISH holds until the last
// response is taken. After reset the store is swept to blanks with req_ready
// low; the cursor resets to the top left.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_cell_writer_unit #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int TAB_STOP      = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tcw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  tcw_pkg::req_t                    req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output tcw_pkg::rsp_t                    rsp
);

  localparam int CELL_COUNT  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int MOVE_COUNT  = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int SWEEP_W     = $clog2(CELL_COUNT + 1);
  localparam int COL_W       = $clog2(SCREEN_WIDTH);
  localparam int ROW_W       = $clog2(SCREEN_HEIGHT);
  localparam int TCOL_W      = $clog2(SCREEN_WIDTH + TAB_STOP);
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + TAB_STOP - 1) / TAB_STOP;
  localparam int PROD_W      = COL_W + RECIP_SHIFT + 1;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_MOVE,
    S_FINISH
  } state_t;

  state_t              state;
  logic [SWEEP_W-1:0]  sweep;
  logic                booting;
  logic [15:0]         fill_cell;
  logic [COL_W-1:0]    cursor_col;
  logic [ROW_W-1:0]    cursor_row;
  logic [3:0]          fg_color;
  logic [3:0]          bg_color;
  logic [COL_W-1:0]    tab_quot;
  logic [1:0]          op_q;
  logic [7:0]          char_q;
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [15:0]         cell_data_q;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [15:0]         mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [15:0]         mem_rdata;

  logic [PROD_W-1:0]   tab_prod;
  logic [COL_W-1:0]    col_clamp;
  logic [ROW_W-1:0]    row_clamp;
  logic [ADDR_W-1:0]   cur_addr;
  logic [ADDR_W-1:0]   sel_addr;
  logic [15:0]         blank_cell;
  logic [TCOL_W-1:0]   tab_col;
  logic [TCOL_W-1:0]   put_col;
  logic [ROW_W:0]      put_row;
  logic                put_we;
  logic [ADDR_W-1:0]   put_waddr;
  logic [15:0]         put_wdata;
  logic [COL_W-1:0]    wrap_col;
  logic [ROW_W:0]      wrap_row;
  logic                scroll;
  logic [10:0]         pos;

  assign req_ready  = (state == S_IDLE);
  assign blank_cell = {bg_color, fg_color, tcw_pkg::CHAR_BLANK};

  assign col_clamp = (32'(req.column) >= SCREEN_WIDTH) ? COL_W'(SCREEN_WIDTH - 1)
                                                       : COL_W'(req.column);
  assign row_clamp = (32'(req.row_index) >= SCREEN_HEIGHT) ? ROW_W'(SCREEN_HEIGHT - 1)
                                                           : ROW_W'(req.row_index);

  assign tab_prod = PROD_W'(cursor_col) * PROD_W'(RECIP);
  assign tab_col  = TCOL_W'((32'(tab_quot) + 32'd1) * TAB_STOP);
  assign cur_addr = ADDR_W'(32'(cursor_row) * SCREEN_WIDTH + 32'(cursor_col));
  assign sel_addr = ADDR_W'(32'(row_q) * SCREEN_WIDTH + 32'(col_q));
  assign pos      = 11'(32'(cursor_row) * SCREEN_WIDTH + 32'(cursor_col));

  always_comb begin
    put_col   = TCOL_W'(cursor_col);
    put_row   = (ROW_W+1)'(cursor_row);
    put_we    = 1'b0;
    put_waddr = cur_addr;
    put_wdata = {bg_color, fg_color, char_q};
    case (char_q)
      tcw_pkg::CHAR_NEWLINE: begin
        put_col = '0;
        put_row = (ROW_W+1)'(cursor_row) + 1'b1;
      end
      tcw_pkg::CHAR_RETURN: begin
        put_col = '0;
      end
      tcw_pkg::CHAR_TAB: begin
        put_col = tab_col;
      end
      tcw_pkg::CHAR_BACKSPACE: begin
        if (cursor_col != '0) begin
          put_col   = TCOL_W'(cursor_col) - 1'b1;
          put_we    = 1'b1;
          put_waddr = cur_addr - 1'b1;
          put_wdata = blank_cell;
        end
      end
      default: begin
        put_col = TCOL_W'(cursor_col) + 1'b1;
        put_we  = 1'b1;
      end
    endcase
    if (32'(put_col) >= SCREEN_WIDTH) begin
      wrap_col = '0;
      wrap_row = put_row + 1'b1;
    end else begin
      wrap_col = COL_W'(put_col);
      wrap_row = put_row;
    end
    scroll = (32'(wrap_row) >= SCREEN_HEIGHT);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = put_waddr;
    mem_wdata = put_wdata;
    mem_re    = 1'b0;
    mem_raddr = sel_addr;
    case (state)
      S_EXEC: begin
        mem_we = (tcw_pkg::opcode_t'(op_q) == tcw_pkg::OP_PUT_CHAR) && put_we;
        mem_re = (tcw_pkg::opcode_t'(op_q) == tcw_pkg::OP_READ_CELL);
      end
      S_MOVE: begin
        mem_re    = (32'(sweep) < MOVE_COUNT);
        mem_raddr = ADDR_W'(32'(sweep) + SCREEN_WIDTH);
        mem_we    = (sweep != '0);
        mem_waddr = ADDR_W'(sweep - 1'b1);
        mem_wdata = mem_rdata;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = sweep[ADDR_W-1:0];
        mem_wdata = fill_cell;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  tcw_screen_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W),
    .DATA_W (16)
  ) u_screen_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      sweep      <= '0;
      booting    <= 1'b1;
      fill_cell  <= tcw_pkg::RESET_BLANK;
      cursor_col <= '0;
      cursor_row <= '0;
      fg_color   <= tcw_pkg::FG_RESET;
      bg_color   <= tcw_pkg::BG_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      tab_quot <= tab_prod[PROD_W-2:RECIP_SHIFT];
      if (cfg_we) begin
        case (tcw_pkg::cfg_index_t'(cfg_index))
          tcw_pkg::CFG_FG_COLOR: fg_color <= cfg_data;
          tcw_pkg::CFG_BG_COLOR: bg_color <= cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          if (32'(sweep) == CELL_COUNT - 1) begin
            sweep   <= '0;
            booting <= 1'b0;
            state   <= booting ? S_IDLE : S_FINISH;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op_q   <= req.opcode;
            char_q <= req.char_code;
            col_q  <= col_clamp;
            row_q  <= row_clamp;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          cell_data_q <= '0;
          case (tcw_pkg::opcode_t'(op_q))
            tcw_pkg::OP_PUT_CHAR: begin
              cursor_col <= wrap_col;
              if (scroll) begin
                cursor_row <= ROW_W'(SCREEN_HEIGHT - 1);
                sweep      <= '0;
                fill_cell  <= blank_cell;
                state      <= S_MOVE;
              end else begin
                cursor_row <= wrap_row[ROW_W-1:0];
                state      <= S_FINISH;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              cursor_col <= '0;
              cursor_row <= '0;
              sweep      <= '0;
              fill_cell  <= blank_cell;
              state      <= S_FILL;
            end
            tcw_pkg::OP_SET_CURSOR: begin
              cursor_col <= col_q;
              cursor_row <= row_q;
              state      <= S_FINISH;
            end
            default: begin
              state <= S_READ;
            end
          endcase
        end
        S_READ: begin
          cell_data_q <= mem_rdata;
          state       <= S_FINISH;
        end
        S_MOVE: begin
          if (32'(sweep) == MOVE_COUNT) begin
            state <= S_FILL;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            rsp.cursor_pos <= pos;
            rsp.cell_data  <= cell_data_q;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_one_request_at_a_time, clk, rst, req_valid && req_ready, !req_ready)
  `ASSERT_IMPL(a_cursor_on_screen, clk, rst, state == S_IDLE,
    (32'(cursor_col) < SCREEN_WIDTH) && (32'(cursor_row) < SCREEN_HEIGHT))
  `ASSERT_IMPL(a_write_in_range, clk, rst, mem_we, 32'(mem_waddr) < CELL_COUNT)
  `ASSERT_IMPL(a_rsp_from_finish, clk, rst, $rose(rsp_valid), $past(state == S_FINISH))

endmodule
